>>> rtl/fsre_pkg.sv
// shared constants and types for the centered fir filter with replicated edges
// no dependencies; used by every module of the block
`default_nettype none

package fsre_pkg;

    // defaults for the top-level parameters
    localparam int MAX_TAPS_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    // fixed field widths
    localparam int OUT_BITS       = 40;
    localparam int TAPS_CFG_BITS  = 6;
    localparam int TAP_INDEX_BITS = 5;

    // input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // sequencer modes
    typedef enum logic {
        MODE_STREAM,
        MODE_FLUSH
    } mode_t;

    // per-step control fanned out to every cell
    typedef struct packed {
        logic adv;
        logic fill;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/fsre_tap_cell.sv
// one cell of the tap chain: window sample, coefficient and registered product
// depends on fsre_pkg
`default_nettype none

module fsre_tap_cell #(
    parameter int SAMPLE_BITS = fsre_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fsre_pkg::COEF_BITS_DEF
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  fsre_pkg::cell_ctl_t                      ctl,
    input  wire                                      coef_we,
    input  wire  signed [COEF_BITS-1:0]              coef_in,
    input  wire  signed [SAMPLE_BITS-1:0]            fill_val,
    input  wire  signed [SAMPLE_BITS-1:0]            win_in,
    input  wire                                      tap_on,
    output logic signed [SAMPLE_BITS-1:0]            win_out,
    output logic signed [fsre_pkg::OUT_BITS-1:0]     prod
);

    logic signed [SAMPLE_BITS-1:0]           win_reg;
    logic signed [COEF_BITS-1:0]             coef_reg;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] mult;
    logic signed [fsre_pkg::OUT_BITS-1:0]    prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (coef_we)
        begin
            coef_reg <= coef_in;
        end
    end

    // window moves one cell per step, or takes the first sample of a record everywhere
    always_ff @(posedge clk)
    begin
        if (ctl.fill)
        begin
            win_reg <= fill_val;
        end
        else if (ctl.shift)
        begin
            win_reg <= win_in;
        end
    end

    assign mult = coef_reg * win_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg <= tap_on ? fsre_pkg::OUT_BITS'(mult) : '0;
        end
    end

    assign win_out = win_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> rtl/fsre_add_tree.sv
// registered binary adder tree over the cell products, one register per level
// depends on fsre_pkg
`default_nettype none

module fsre_add_tree #(
    parameter int N = fsre_pkg::MAX_TAPS_DEF
) (
    input  wire                                   clk,
    input  wire                                   en,
    input  wire  signed [fsre_pkg::OUT_BITS-1:0]  leaf [N],
    output logic signed [fsre_pkg::OUT_BITS-1:0]  sum
);

    localparam int LV = $clog2(N);
    localparam int NP = 1 << LV;

    if (LV == 0)
    begin : g_flat
        assign sum = leaf[0];
    end
    else
    begin : g_tree
        // heap layout: node 0 is the root, leaves sit at NP-1 and up
        logic signed [fsre_pkg::OUT_BITS-1:0] node     [2*NP-1];
        logic signed [fsre_pkg::OUT_BITS-1:0] node_reg [NP-1];

        // combined view of the sums and the zero-padded leaves
        always_comb
        begin
            for (int i = 0; i < NP-1; i++)
            begin
                node[i] = node_reg[i];
            end
            for (int i = 0; i < N; i++)
            begin
                node[NP-1+i] = leaf[i];
            end
            for (int i = N; i < NP; i++)
            begin
                node[NP-1+i] = '0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < NP-1; i++)
                begin
                    node_reg[i] <= node[2*i+1] + node[2*i+2];
                end
            end
        end

        assign sum = node_reg[0];
    end

endmodule

`default_nettype wire

>>> rtl/fir_same_replicate_edges.sv
// top level of the centered same-length fir filter with replicated record edges
// depends on fsre_pkg, fsre_tap_cell and fsre_add_tree
`default_nettype none

//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_stall    | cmd, tap_index, tap_value, sample, record_end
//  out     | out_valid / out_stall  | filtered, out_last
//  config  | cfg_write              | taps_in_use
//
//  one beat per cycle on the input while in_stall is low, loads and samples alike;
//  a record_end sample then holds in_stall high while the sequencer feeds
//  floor(K/2) copies of it through the tap chain
//  a result passes through the window register, the product register, the adder
//  tree level registers and the output register
//  while a result waits under out_stall the whole pipe freezes and in_stall rises
//  reset clears coefficients, taps_in_use to 1 and all control; no clearing pass

module fir_same_replicate_edges #(
    parameter int MAX_TAPS    = fsre_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fsre_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fsre_pkg::COEF_BITS_DEF
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    // configuration
    input  wire                                      cfg_write,
    input  wire  [fsre_pkg::TAPS_CFG_BITS-1:0]       taps_in_use,
    // input beats
    input  wire                                      in_valid,
    output logic                                     in_stall,
    input  wire                                      cmd,
    input  wire  [fsre_pkg::TAP_INDEX_BITS-1:0]      tap_index,
    input  wire  signed [COEF_BITS-1:0]              tap_value,
    input  wire  signed [SAMPLE_BITS-1:0]            sample,
    input  wire                                      record_end,
    // result beats
    output logic                                     out_valid,
    input  wire                                      out_stall,
    output logic signed [fsre_pkg::OUT_BITS-1:0]     filtered,
    output logic                                     out_last
);

    localparam int HALF_MAX = MAX_TAPS / 2;
    localparam int PW       = $clog2(HALF_MAX + 2);
    localparam int KW       = $clog2(MAX_TAPS + 1);
    localparam int CW       = (KW > fsre_pkg::TAPS_CFG_BITS) ? KW : fsre_pkg::TAPS_CFG_BITS;
    localparam int TREE_LV  = $clog2(MAX_TAPS);

    // configuration register and effective kernel length
    logic [fsre_pkg::TAPS_CFG_BITS-1:0] taps_reg;
    logic [CW-1:0]                      taps_ext;
    logic [CW-1:0]                      k_len;
    logic [CW-1:0]                      h_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= fsre_pkg::TAPS_CFG_BITS'(1);
        end
        else if (cfg_write)
        begin
            taps_reg <= taps_in_use;
        end
    end

    // zero acts as one tap, anything past the chain length as the full chain
    assign taps_ext = CW'(taps_reg);
    always_comb
    begin
        if (taps_ext == '0)
        begin
            k_len = CW'(1);
        end
        else if (taps_ext > CW'(MAX_TAPS))
        begin
            k_len = CW'(MAX_TAPS);
        end
        else
        begin
            k_len = taps_ext;
        end
    end
    assign h_len = k_len >> 1;

    // handshake: everything advances together unless a result is held
    logic out_valid_reg;
    logic adv;
    logic in_acc;
    logic smp_acc;
    logic ld_acc;

    fsre_pkg::mode_t state_reg;
    fsre_pkg::mode_t state_next;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv || (state_reg == fsre_pkg::MODE_FLUSH);
    assign in_acc   = in_valid && !in_stall;
    assign smp_acc  = in_acc && (cmd == fsre_pkg::CMD_SAMPLE);
    assign ld_acc   = in_acc && (cmd == fsre_pkg::CMD_LOAD);

    // record sequencer state
    logic [PW-1:0]          pend_reg;
    logic [PW-1:0]          pend_next;
    logic [PW-1:0]          pend_eff;
    logic [PW-1:0]          pend_inc;
    logic                   inrec_reg;
    logic                   inrec_next;
    logic [CW-1:0]          fcnt_reg;
    logic [CW-1:0]          fcnt_next;
    logic signed [SAMPLE_BITS-1:0] fval_reg;
    logic signed [SAMPLE_BITS-1:0] fval_next;
    logic signed [SAMPLE_BITS-1:0] src_val;
    logic                   step_fill;
    logic                   step_shift;
    logic                   step_emit;
    logic                   step_last;

    // samples already taken in this record, saturating at half the chain
    assign pend_eff = inrec_reg ? pend_reg : '0;
    assign pend_inc = (pend_eff < PW'(HALF_MAX)) ? pend_eff + PW'(1) : pend_eff;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsre_pkg::MODE_STREAM:
            begin
                if (smp_acc && record_end && (h_len != '0))
                begin
                    state_next = fsre_pkg::MODE_FLUSH;
                end
            end
            fsre_pkg::MODE_FLUSH:
            begin
                if (adv && (fcnt_reg == CW'(1)))
                begin
                    state_next = fsre_pkg::MODE_STREAM;
                end
            end
            default:
            begin
                state_next = fsre_pkg::MODE_STREAM;
            end
        endcase
    end

    always_comb
    begin
        step_fill  = 1'b0;
        step_shift = 1'b0;
        step_emit  = 1'b0;
        step_last  = 1'b0;
        src_val    = sample;
        pend_next  = pend_reg;
        inrec_next = inrec_reg;
        fcnt_next  = fcnt_reg;
        fval_next  = fval_reg;
        case (state_reg)
            fsre_pkg::MODE_STREAM:
            begin
                if (smp_acc)
                begin
                    // first sample of a record fills the whole window
                    step_fill  = !inrec_reg;
                    step_shift = inrec_reg;
                    step_emit  = (CW'(pend_eff) >= h_len);
                    if (record_end && (h_len == '0))
                    begin
                        // single-tap kernel: no flush, this result ends the record
                        step_last  = step_emit;
                        pend_next  = '0;
                        inrec_next = 1'b0;
                    end
                    else if (record_end)
                    begin
                        pend_next  = pend_eff;
                        inrec_next = 1'b1;
                        fcnt_next  = h_len;
                        fval_next  = sample;
                    end
                    else
                    begin
                        pend_next  = pend_inc;
                        inrec_next = 1'b1;
                    end
                end
            end
            fsre_pkg::MODE_FLUSH:
            begin
                // replicate the last sample past the end of the record
                src_val = fval_reg;
                if (adv)
                begin
                    step_shift = 1'b1;
                    step_emit  = (CW'(pend_inc) >= h_len);
                    fcnt_next  = fcnt_reg - CW'(1);
                    if (fcnt_reg == CW'(1))
                    begin
                        step_last  = step_emit;
                        pend_next  = '0;
                        inrec_next = 1'b0;
                    end
                    else
                    begin
                        pend_next = pend_inc;
                    end
                end
            end
            default:
            begin
                step_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsre_pkg::MODE_STREAM;
            pend_reg  <= '0;
            inrec_reg <= 1'b0;
            fcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            inrec_reg <= inrec_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fval_reg <= fval_next;
    end

    // tap chain
    fsre_pkg::cell_ctl_t cell_ctl;
    logic signed [SAMPLE_BITS-1:0]        win_tap [MAX_TAPS];
    logic signed [fsre_pkg::OUT_BITS-1:0] prod    [MAX_TAPS];

    assign cell_ctl.adv   = adv;
    assign cell_ctl.fill  = step_fill;
    assign cell_ctl.shift = step_shift;

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] win_prev;
        logic                          coef_we;
        logic                          tap_on;

        if (j == 0)
        begin : g_head
            assign win_prev = src_val;
        end
        else
        begin : g_link
            assign win_prev = win_tap[j-1];
        end

        assign coef_we = ld_acc && (32'(j) == 32'(tap_index));
        assign tap_on  = (CW'(j) < k_len);

        fsre_tap_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .coef_we  (coef_we),
            .coef_in  (tap_value),
            .fill_val (src_val),
            .win_in   (win_prev),
            .tap_on   (tap_on),
            .win_out  (win_tap[j]),
            .prod     (prod[j])
        );
    end

    // result markers travel beside the data: window stage, product stage, tree
    logic s0_valid_reg;
    logic s0_last_reg;
    logic s1_valid_reg;
    logic s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_last_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= step_emit;
            s0_last_reg  <= step_last;
            s1_valid_reg <= s0_valid_reg;
            s1_last_reg  <= s0_last_reg;
        end
    end

    logic signed [fsre_pkg::OUT_BITS-1:0] tree_sum;
    logic                                 tree_valid;
    logic                                 tree_last;

    fsre_add_tree #(
        .N (MAX_TAPS)
    ) u_tree (
        .clk  (clk),
        .en   (adv),
        .leaf (prod),
        .sum  (tree_sum)
    );

    if (TREE_LV == 0)
    begin : g_no_pipe
        assign tree_valid = s1_valid_reg;
        assign tree_last  = s1_last_reg;
    end
    else
    begin : g_pipe
        logic [TREE_LV-1:0] vpipe_reg;
        logic [TREE_LV-1:0] lpipe_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vpipe_reg <= '0;
                lpipe_reg <= '0;
            end
            else if (adv)
            begin
                vpipe_reg[0] <= s1_valid_reg;
                lpipe_reg[0] <= s1_last_reg;
                for (int i = 1; i < TREE_LV; i++)
                begin
                    vpipe_reg[i] <= vpipe_reg[i-1];
                    lpipe_reg[i] <= lpipe_reg[i-1];
                end
            end
        end

        assign tree_valid = vpipe_reg[TREE_LV-1];
        assign tree_last  = lpipe_reg[TREE_LV-1];
    end

    // output register
    logic signed [fsre_pkg::OUT_BITS-1:0] filtered_reg;
    logic                                 out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tree_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            filtered_reg <= tree_sum;
            out_last_reg <= tree_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> tb/fsre_sum_checker.sv
// result checker for fir_same_replicate_edges: tracks coefficients, window and record state
// from the accepted beats and compares every result beat; depends on fsre_pkg only
`default_nettype none

module fsre_sum_checker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_write,
    input  wire  [fsre_pkg::TAPS_CFG_BITS-1:0]    taps_in_use,
    input  wire                                   in_valid,
    input  wire                                   in_stall,
    input  wire                                   cmd,
    input  wire  [fsre_pkg::TAP_INDEX_BITS-1:0]   tap_index,
    input  wire  signed [15:0]                    tap_value,
    input  wire  signed [15:0]                    sample,
    input  wire                                   record_end,
    input  wire                                   out_valid,
    input  wire                                   out_stall,
    input  wire  signed [fsre_pkg::OUT_BITS-1:0]  filtered,
    input  wire                                   out_last,
    output int                                    fail_count,
    output int                                    results_left,
    output int                                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TAPS = fsre_pkg::MAX_TAPS_DEF;
    localparam int HALF_MAX = MAX_TAPS / 2;

    logic signed [15:0]                   coef_mem [MAX_TAPS];
    logic signed [15:0]                   win      [MAX_TAPS];
    logic [fsre_pkg::TAPS_CFG_BITS-1:0]   k_reg;
    int                                   taken;
    bit                                   in_rec;
    logic signed [fsre_pkg::OUT_BITS-1:0] sums_due [$];
    bit                                   last_due [$];
    int                                   errors;
    int                                   seen;

    function automatic int kernel_len();
        int k;
        k = k_reg;
        if (k == 0)
            k = 1;
        if (k > MAX_TAPS)
            k = MAX_TAPS;
        return k;
    endfunction

    function automatic logic signed [fsre_pkg::OUT_BITS-1:0] centered_sum(int k);
        longint acc;
        acc = 0;
        for (int j = 0; j < k; j++)
            acc += longint'(coef_mem[j]) * longint'(win[j]);
        return acc[fsre_pkg::OUT_BITS-1:0];
    endfunction

    task automatic shift_window(logic signed [15:0] s);
        for (int i = MAX_TAPS - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = s;
    endtask

    task automatic due(int k);
        sums_due.push_back(centered_sum(k));
        last_due.push_back(1'b0);
    endtask

    // one accepted input beat
    task automatic take_beat();
        int k;
        int h;
        int n;
        k = kernel_len();
        h = k / 2;
        n = 0;
        if (cmd == fsre_pkg::CMD_LOAD)
        begin
            if (tap_index < MAX_TAPS)
                coef_mem[tap_index] = tap_value;
        end
        else
        begin
            if (!in_rec)
            begin
                for (int i = 0; i < MAX_TAPS; i++)
                    win[i] = sample;
                taken = 0;
                in_rec = 1'b1;
            end
            else
                shift_window(sample);
            if (taken >= h)
            begin
                due(k);
                n++;
            end
            if (record_end)
            begin
                // trailing edge: feed copies of the last sample
                for (int c = 0; c < h; c++)
                begin
                    if (taken < HALF_MAX)
                        taken++;
                    shift_window(sample);
                    if (taken >= h)
                    begin
                        due(k);
                        n++;
                    end
                end
                if (n > 0)
                    last_due[last_due.size() - 1] = 1'b1;
                in_rec = 1'b0;
                taken = 0;
            end
            else if (taken < HALF_MAX)
                taken++;
        end
    endtask

    task automatic check_result();
        logic signed [fsre_pkg::OUT_BITS-1:0] want;
        bit                                   want_last;
        seen++;
        if (sums_due.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with nothing expected, filtered %0d last %0b",
                     $time, filtered, out_last);
        end
        else
        begin
            want = sums_due.pop_front();
            want_last = last_due.pop_front();
            if (filtered !== want)
            begin
                errors++;
                $display("%0t: filtered expected %0d actual %0d", $time, want, filtered);
            end
            if (out_last !== want_last)
            begin
                errors++;
                $display("%0t: out_last expected %0b actual %0b", $time, want_last, out_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_mem[i] = '0;
                win[i] = '0;
            end
            k_reg = 1;
            taken = 0;
            in_rec = 1'b0;
            sums_due.delete();
            last_due.delete();
            errors = 0;
            seen = 0;
            fail_count <= 0;
            results_left <= 0;
            results_seen <= 0;
        end
        else
        begin
            // results first so a stray beat can never consume a fresh expectation
            if (out_valid && !out_stall)
                check_result();
            if (cfg_write)
                k_reg = taps_in_use;
            if (in_valid && !in_stall)
                take_beat();
            fail_count <= errors;
            results_left <= sums_due.size();
            results_seen <= seen;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// top of the testbench for fir_same_replicate_edges: clock, reset, stimulus and verdict
// depends on fsre_pkg, the block itself and fsre_sum_checker
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam time CLK_PERIOD   = 20ns;
    // result path of the block: window, products, five tree levels, output reg
    localparam int  LATENCY      = 3 + $clog2(fsre_pkg::MAX_TAPS_DEF);
    localparam int  SETTLE       = 2 * LATENCY;
    localparam int  RANDOM_BEATS = 130;
    // cycles without any beat on either channel before the run is declared hung
    localparam int  QUIET_LIMIT  = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                  cfg_write = 1'b0;
    logic [fsre_pkg::TAPS_CFG_BITS-1:0]    taps_in_use = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic                                  cmd = fsre_pkg::CMD_LOAD;
    logic [fsre_pkg::TAP_INDEX_BITS-1:0]   tap_index = '0;
    logic signed [15:0]                    tap_value = '0;
    logic signed [15:0]                    sample = '0;
    logic                                  record_end = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [fsre_pkg::OUT_BITS-1:0]  filtered;
    logic                                  out_last;

    int fail_count;
    int results_left;
    int results_seen;
    int beats_sent = 0;
    int taps_writes = 0;
    int records_done = 0;
    int quiet = 0;
    // calm = no idling on either side, for one long stretch of the random part
    bit calm = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    fir_same_replicate_edges u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .taps_in_use (taps_in_use),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .tap_index   (tap_index),
        .tap_value   (tap_value),
        .sample      (sample),
        .record_end  (record_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered),
        .out_last    (out_last)
    );

    fsre_sum_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .taps_in_use  (taps_in_use),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .tap_index    (tap_index),
        .tap_value    (tap_value),
        .sample       (sample),
        .record_end   (record_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .out_last     (out_last),
        .fail_count   (fail_count),
        .results_left (results_left),
        .results_seen (results_seen)
    );

    // receiver side: random back-pressure outside the calm stretch, with a chance of about 14 in a hundred
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 14);

    // watchdog on beat activity, not on total run length
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results still due",
                         $time, quiet, results_left);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // mostly ordinary words, with the extremes weighted in
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    // kernel lengths: mostly short, with zero, the max and out-of-range values mixed in
    function automatic logic [5:0] pick_taps();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd63;
            2: return 6'd32;
            3: return 6'($urandom_range(33, 62));
            4: return 6'($urandom_range(9, 31));
            default: return 6'($urandom_range(1, 8));
        endcase
    endfunction

    // one input beat; outside wait_idle, the idle gap before it is the only point where valid drops
    task automatic send_beat(logic op, logic [4:0] idx, logic [15:0] coef,
                             logic [15:0] smp, logic fin);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        tap_index  <= idx;
        tap_value  <= coef;
        sample     <= smp;
        record_end <= fin;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        if (op == fsre_pkg::CMD_SAMPLE && fin)
            records_done++;
    endtask

    // tap loads carry junk in the sample fields, which the block must ignore
    task automatic send_load(logic [4:0] idx, logic [15:0] coef);
        send_beat(fsre_pkg::CMD_LOAD, idx, coef, rand_word(), 1'($urandom));
    endtask

    // and sample beats carry junk in the tap fields
    task automatic send_sample(logic [15:0] smp, logic fin);
        send_beat(fsre_pkg::CMD_SAMPLE, 5'($urandom), rand_word(), smp, fin);
    endtask

    // a beat that gives no result can still be in the pipe when the last result is out,
    // so give the pipe time to drain before touching the register
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_left != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_taps(logic [5:0] k);
        wait_idle();
        cfg_write   <= 1'b1;
        taps_in_use <= k;
        @(posedge clk);
        cfg_write   <= 1'b0;
        taps_writes++;
    endtask

    initial
    begin
        int rand_start;
        int len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // kernel length 1 from reset: each sample is its own result, no trailing copies
        send_load(5'd0, 16'h8000);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);

        // zero kernel length behaves as length 1; single-sample record
        set_taps(6'd0);
        send_load(5'd31, 16'h7fff);
        send_sample(16'h3039, 1'b1);

        // length above the max clamps to 32: a 3-sample record is shorter than
        // the half kernel, so all results come out of the record-end beat
        set_taps(6'd63);
        send_load(5'd1, 16'h7fff);
        send_load(5'd16, 16'hffff);
        send_load(5'd0, 16'h7fff);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0005, 1'b1);

        // length 5 with a coefficient reload in the middle of a record
        set_taps(6'd5);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hedcb, 1'b0);
        send_load(5'd2, 16'h8000);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);

        // kernel length raised from 3 to 32 while a record is open
        set_taps(6'd3);
        send_sample(16'h0100, 1'b0);
        send_sample(16'hff00, 1'b0);
        set_taps(6'd32);
        send_sample(16'h7fff, 1'b1);

        // random part: records of random length and content, loads and
        // kernel changes sprinkled in, one long calm stretch in the middle
        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            calm = (beats_sent - rand_start >= 50) && (beats_sent - rand_start < 100);
            if ($urandom_range(0, 1))
                set_taps(pick_taps());
            repeat ($urandom_range(0, 3))
                send_load(5'($urandom_range(0, $urandom_range(0, 1) ? 7 : 31)), rand_word());
            // mostly short records, a few long ones of 13 to 40 samples, most past the largest half kernel
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 99) < 10)
                    send_load(5'($urandom), rand_word());
                if (i > 0 && $urandom_range(0, 99) < 6)
                    set_taps(pick_taps());
                send_sample(rand_word(), i == len - 1);
            end
        end
        calm = 1'b0;

        // drain, then give a stray late result time to show up
        wait_idle();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d input beats in %0d records, %0d kernel length writes,",
                 beats_sent, records_done, taps_writes);
        $display("and %0d result beats checked against the prediction", results_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
